// File: sv/slsu_pkg.sv
// Shared types and constants for the segmented load/store unit.
// No dependencies; imported by slsu_ctrl, slsu_datapath and the top level.
`timescale 1ns / 1ps

package slsu_pkg;

   // physical memory
   localparam int unsigned MEM_BYTES = 1048576;
   localparam int unsigned PA_W      = 20;

   // segment bounds and offsets
   localparam logic [31:0] STACK_LO   = 32'h7FF8_0000;
   localparam logic [31:0] STACK_HI   = 32'h7FFF_FFFC;
   localparam logic [31:0] STACK_OFFS = 32'h7FF0_0000;
   localparam logic [31:0] DATA_LO    = 32'h1000_0000;
   localparam logic [31:0] DATA_END   = 32'h1004_0000;
   localparam logic [31:0] DATA_OFFS  = 32'h0FFC_0000;
   localparam logic [31:0] TEXT_END   = 32'h0004_0000;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SEGV  = 2'd1;
   localparam logic [1:0] ST_ALIGN = 2'd2;

   // access size codes
   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_WORD = 2'd2;

   // action codes
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_STORE = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACCESS,
      S_DONE
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request fields
      logic issue;     // one byte access to memory
      logic out_load;  // move result into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic fault;     // captured request faulted
      logic last;      // current byte is the final one
      logic out_busy;  // output register held by a stall
   } sts_type;

endpackage

// File: sv/slsu_ctrl.sv
// Controller state machine for the segmented load/store unit.
// Depends on slsu_pkg; drives command signals to slsu_datapath.
`timescale 1ns / 1ps

module slsu_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  slsu_pkg::sts_type sts,
   output slsu_pkg::cmd_type cmd
);
   import slsu_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_ACCESS;
            end
         end
         S_ACCESS: begin
            if (sts.fault) begin
               state_in = S_DONE;
            end else begin
               cmd.issue = 1'b1;
               if (sts.last) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // a faulted access never touches memory
   a_no_issue_on_fault: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !sts.fault)
      else $error("memory access issued for a faulted request");

   // every accepted request is followed by memory work or the result step
   a_accept_then_access: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_ACCESS))
      else $error("accepted request did not start an access");
`endif

endmodule

// File: sv/slsu_datapath.sv
// Datapath for the segmented load/store unit: address map, fault checks,
// byte memory, load assembly and output register. Depends on slsu_pkg.
`timescale 1ns / 1ps

module slsu_datapath (
   input  logic              clock,
   input  logic              reset,
   input  slsu_pkg::cmd_type cmd,
   output slsu_pkg::sts_type sts,
   input  logic              req_action,
   input  logic [31:0]       req_vaddr,
   input  logic [1:0]        req_access_size,
   input  logic [31:0]       req_write_data,
   input  logic              req_align_check,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [31:0]       rsp_read_data,
   output logic [1:0]        rsp_status
);
   import slsu_pkg::*;

   logic [7:0] mem [MEM_BYTES];

   // captured request
   logic            store_ff;
   logic [PA_W-1:0] pa_ff;
   logic [31:0]     wdata_ff;
   logic [1:0]      status_ff;
   logic [1:0]      last_ff;
   logic [1:0]      idx_ff;

   // load assembly
   logic [7:0]  rd_ff;
   logic        cap_pend_ff;
   logic [1:0]  cap_idx_ff;
   logic [31:0] acc_ff;
   logic [31:0] acc_merged;

   // output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_read_data_ff;
   logic [1:0]  rsp_status_ff;

   // request decode
   logic            stack_hit, data_hit, text_hit;
   logic [PA_W-1:0] pa_in;
   logic            misalign;
   logic [1:0]      status_in;
   logic [1:0]      last_in;

   logic [PA_W-1:0] mem_addr;
   logic [7:0]      mem_wbyte;
   logic            mem_we, mem_re;

   always_comb begin
      stack_hit = (req_vaddr >= STACK_LO) && (req_vaddr <= STACK_HI);
      data_hit  = (req_vaddr >= DATA_LO) && (req_vaddr < DATA_END);
      text_hit  = (req_vaddr < TEXT_END);

      if (stack_hit) begin
         pa_in = PA_W'(req_vaddr - STACK_OFFS);
      end else if (data_hit) begin
         pa_in = PA_W'(req_vaddr - DATA_OFFS);
      end else begin
         pa_in = req_vaddr[PA_W-1:0];
      end

      case (req_access_size)
         SZ_BYTE: begin
            misalign = 1'b0;
            last_in  = 2'd0;
         end
         SZ_HALF: begin
            misalign = pa_in[0];
            last_in  = 2'd1;
         end
         SZ_WORD: begin
            misalign = (pa_in[1:0] != 2'd0);
            last_in  = 2'd3;
         end
         default: begin
            // unused size code: byte access, always misaligned when checked
            misalign = 1'b1;
            last_in  = 2'd0;
         end
      endcase

      if (!(stack_hit || data_hit || text_hit)) begin
         status_in = ST_SEGV;
      end else if ((req_action == ACT_STORE) && text_hit) begin
         status_in = ST_SEGV;
      end else if (req_align_check && misalign) begin
         status_in = ST_ALIGN;
      end else begin
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         store_ff  <= req_action;
         pa_ff     <= pa_in;
         wdata_ff  <= req_write_data;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= 2'd0;
      end else if (cmd.issue) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   assign mem_addr  = pa_ff + PA_W'(idx_ff);
   assign mem_wbyte = 8'(wdata_ff >> {idx_ff, 3'b000});
   assign mem_we    = cmd.issue && (store_ff == ACT_STORE);
   assign mem_re    = cmd.issue && (store_ff == ACT_LOAD);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wbyte;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_pend_ff <= 1'b0;
      end else begin
         cap_pend_ff <= mem_re;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         cap_idx_ff <= idx_ff;
      end
   end

   assign acc_merged = cap_pend_ff ? (acc_ff | (32'(rd_ff) << {cap_idx_ff, 3'b000})) : acc_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_read_data_ff <= acc_merged;
         rsp_status_ff    <= status_ff;
      end
   end

   assign sts.fault    = (status_ff != ST_OK);
   assign sts.last     = (idx_ff == last_ff);
   assign sts.out_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status    = rsp_status_ff;

`ifndef SYNTHESIS
   // stores never reach the text segment
   a_no_text_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_addr >= PA_W'(TEXT_END)))
      else $error("store reached text segment");

   // a stalled result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("output register overwritten while stalled");

   // faulted results carry zero data
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_read_data_ff == 32'd0))
      else $error("faulted result carries data");
`endif

endmodule

// File: sv/segmented_load_store_unit.sv
// Top level of the segmented load/store unit.
// Depends on slsu_pkg, slsu_ctrl and slsu_datapath.
`timescale 1ns / 1ps

// One memory access per request transfer: a load or store of a byte,
// halfword or word at a 32-bit virtual address, mapped onto a 1 MiB byte
// memory. Stack 0x7FF80000..0x7FFFFFFC, data 0x10000000..0x1003FFFF and
// text below 0x40000 are mapped; anything else, and any store to text,
// returns a segmentation fault. With align_check set, misaligned halfword
// and word accesses return an alignment fault. Faulting accesses change
// nothing and return zero; stores return zero. Loads are little endian
// and zero-extended. Each request yields exactly one response transfer.
// Timing: the memory has one byte-wide port, so an access makes one memory
// step per byte of the request after the request transfer, then moves the
// result into the output register, where the response is valid; a
// faulting access skips the memory steps. The controller is back in idle
// as the result enters the output register. One request is in work at a
// time; the next request is taken as soon as the previous result sits in
// the output register, even while that result is stalled. A finished
// result that finds the output register still held by a stall waits, and
// the request side stalls with it. Memory contents are undefined until
// written; there is no clearing pass after reset.

module segmented_load_store_unit (
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_vaddr,
   input  logic [1:0]  req_access_size,
   input  logic [31:0] req_write_data,
   input  logic        req_align_check,

   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [1:0]  rsp_status
);
   import slsu_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing: accept, per-byte memory steps, hand-off to output
   slsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // address map, checks, memory and result register
   slsu_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_vaddr       (req_vaddr),
      .req_access_size (req_access_size),
      .req_write_data  (req_write_data),
      .req_align_check (req_align_check),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status)
   );

endmodule

// File: tb/tb.sv
// Self-checking testbench for segmented_load_store_unit.
// Depends on slsu_pkg and the RTL of segmented_load_store_unit.
`timescale 1ns / 1ps

// Every request transfer is run through an in-order predictor of the
// address map and the byte memory. The predictor queues the expected
// response, and a checker compares each response transfer with the oldest
// entry. Memory is undefined after reset, so the predictor keeps a shadow
// copy of the written bytes only. A load that would succeed but touch a
// byte never written is turned into a store with the same fields before it
// goes out. Text can never be written, so text loads only ever fault.

module tb;
   import slsu_pkg::*;

   // Size code 3 has no name in the package: a byte access, or an
   // alignment fault when the check is enabled.
   localparam logic [1:0] SZ_RESERVED = 2'd3;

   // The longest quiet stretch in a correct run is the long receiver hold.
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES = 20;

   typedef struct packed {
      logic        action;
      logic [31:0] vaddr;
      logic [1:0]  access_size;
      logic [31:0] write_data;
      logic        align_check;
   } mem_access_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
   } mem_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [31:0] req_vaddr;
   logic [1:0]  req_access_size;
   logic [31:0] req_write_data;
   logic        req_align_check;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_read_data;
   logic [1:0]  rsp_status;

   // Predictor state: bytes written since reset, keyed by physical address.
   logic [7:0]     shadow_mem [int unsigned];
   mem_result_type expected_results [$];

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned burst_left     = 0;
   bit          sender_idles   = 1'b1;
   bit          hold_request   = 1'b0;

   // Address windows for random traffic. The first four sit on segment
   // edges; the last two get random bases when the random test starts.
   // The data-high window reaches across into the stack's physical range,
   // and the stack-high window runs past the mapped top.
   logic [31:0] window_base [6] = '{STACK_LO, STACK_HI - 32'd60, DATA_LO,
                                    DATA_END - 32'd64, STACK_LO, DATA_LO};

   segmented_load_store_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_vaddr       (req_vaddr),
      .req_access_size (req_access_size),
      .req_write_data  (req_write_data),
      .req_align_check (req_align_check),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic mem_access_type make_access(logic action, logic [31:0] vaddr,
                                                  logic [1:0] size, logic [31:0] wdata,
                                                  logic check);
      mem_access_type acc;
      acc = '{action: action, vaddr: vaddr, access_size: size,
              write_data: wdata, align_check: check};
      return acc;
   endfunction

   // Predicts one access and updates the shadow memory. May rewrite an
   // unsafe load into a store, so the caller sends what comes back.
   function automatic mem_result_type resolve_access(inout mem_access_type acc);
      logic [31:0]    pa;
      logic           mapped;
      logic           misaligned;
      int unsigned    nbytes;
      mem_result_type res;
      res    = '{read_data: 32'd0, status: ST_OK};
      mapped = 1'b1;
      pa     = 32'd0;
      if (acc.vaddr >= STACK_LO && acc.vaddr <= STACK_HI) begin
         pa = acc.vaddr - STACK_OFFS;
      end else if (acc.vaddr >= DATA_LO && acc.vaddr < DATA_END) begin
         pa = acc.vaddr - DATA_OFFS;
      end else if (acc.vaddr < TEXT_END) begin
         pa = acc.vaddr;
      end else begin
         mapped = 1'b0;
      end
      nbytes = (acc.access_size == SZ_WORD) ? 4 : (acc.access_size == SZ_HALF) ? 2 : 1;
      misaligned = acc.align_check &&
                   ((acc.access_size == SZ_HALF && pa[0]) ||
                    (acc.access_size == SZ_WORD && pa[1:0] != 2'd0) ||
                    acc.access_size == SZ_RESERVED);
      // never let a load reach a byte that holds no defined value
      if (mapped && acc.action == ACT_LOAD && !misaligned) begin
         for (int i = 0; i < nbytes; i++)
            if (!shadow_mem.exists(pa + i)) acc.action = ACT_STORE;
      end
      // segmentation check first, alignment second
      if (!mapped || (acc.action == ACT_STORE && pa < TEXT_END)) begin
         res.status = ST_SEGV;
      end else if (misaligned) begin
         res.status = ST_ALIGN;
      end else begin
         for (int i = 0; i < nbytes; i++) begin
            if (acc.action == ACT_STORE)
               shadow_mem[pa + i] = acc.write_data[8 * i +: 8];
            else
               res.read_data[8 * i +: 8] = shadow_mem[pa + i];
         end
      end
      return res;
   endfunction

   // Mostly well-formed traffic into small windows so that loads hit
   // stored data; the rest goes to text or anywhere in the 32-bit space.
   function automatic mem_access_type random_access();
      mem_access_type acc;
      int unsigned    sel;
      sel             = $urandom_range(0, 99);
      acc.action      = 1'($urandom_range(0, 1));
      acc.write_data  = $urandom;
      acc.align_check = 1'($urandom_range(0, 1));
      acc.access_size = ($urandom_range(0, 9) == 0) ? SZ_RESERVED
                                                    : 2'($urandom_range(0, 2));
      if (sel < 75)
         acc.vaddr = window_base[$urandom_range(0, 5)] + $urandom_range(0, 63);
      else if (sel < 85)
         acc.vaddr = $urandom_range(0, TEXT_END - 1);
      else
         acc.vaddr = $urandom;
      return acc;
   endfunction

   // Offers one request and returns at the edge where it transfers. The
   // sender runs in bursts; a gap starts at a falling edge with valid low.
   task automatic send_access(input mem_access_type item);
      mem_result_type want;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (sender_idles) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
      end
      burst_left--;
      want = resolve_access(item);
      req_valid       <= 1'b1;
      req_action      <= item.action;
      req_vaddr       <= item.vaddr;
      req_access_size <= item.access_size;
      req_write_data  <= item.write_data;
      req_align_check <= item.align_check;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(want);
   endtask

   // Sender goes quiet until every response has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Segment edges, little-endian layout, zero extension, a store that
   // crosses from data into the stack's physical range.
   task automatic test_segment_edges();
      sender_idles = 1'b1;
      send_access(make_access(ACT_STORE, DATA_LO, SZ_WORD, 32'hDEAD_BEEF, 1'b1));
      send_access(make_access(ACT_LOAD, DATA_LO, SZ_WORD, 32'd0, 1'b1));
      send_access(make_access(ACT_LOAD, DATA_LO + 32'd3, SZ_BYTE, 32'd0, 1'b1));
      send_access(make_access(ACT_LOAD, DATA_LO + 32'd2, SZ_HALF, 32'd0, 1'b1));
      send_access(make_access(ACT_STORE, DATA_LO + 32'd1, SZ_HALF, 32'hFFFF_8001, 1'b0));
      send_access(make_access(ACT_LOAD, DATA_LO, SZ_WORD, 32'd0, 1'b0));
      send_access(make_access(ACT_STORE, STACK_HI, SZ_WORD, 32'hFFFF_FFFF, 1'b1));
      send_access(make_access(ACT_LOAD, STACK_HI, SZ_WORD, 32'd0, 1'b1));
      send_access(make_access(ACT_LOAD, STACK_HI + 32'd1, SZ_BYTE, 32'd0, 1'b0));
      send_access(make_access(ACT_STORE, STACK_LO, SZ_WORD, 32'h0000_0000, 1'b1));
      send_access(make_access(ACT_LOAD, STACK_LO, SZ_HALF, 32'd0, 1'b1));
      send_access(make_access(ACT_STORE, DATA_END - 32'd2, SZ_WORD, 32'hA5C3_1234, 1'b0));
      send_access(make_access(ACT_LOAD, STACK_LO, SZ_WORD, 32'd0, 1'b1));
      send_access(make_access(ACT_LOAD, DATA_END - 32'd2, SZ_WORD, 32'd0, 1'b0));
      send_access(make_access(ACT_LOAD, STACK_LO - 32'd1, SZ_BYTE, 32'd0, 1'b0));
      send_access(make_access(ACT_STORE, DATA_END, SZ_BYTE, 32'h0000_00FF, 1'b0));
      send_access(make_access(ACT_LOAD, 32'hFFFF_FFFF, SZ_WORD, 32'd0, 1'b0));
      send_access(make_access(ACT_STORE, 32'h0000_0000, SZ_BYTE, 32'h0000_0055, 1'b0));
      send_access(make_access(ACT_STORE, TEXT_END - 32'd4, SZ_WORD, 32'h1234_5678, 1'b1));
   endtask

   // Fault priority, misalignment per size, and the reserved size code.
   task automatic test_fault_cases();
      send_access(make_access(ACT_LOAD, 32'h0000_0001, SZ_HALF, 32'd0, 1'b1));
      send_access(make_access(ACT_STORE, 32'h0000_0003, SZ_WORD, 32'hCAFE_F00D, 1'b1));
      send_access(make_access(ACT_LOAD, DATA_LO + 32'd2, SZ_WORD, 32'd0, 1'b1));
      send_access(make_access(ACT_LOAD, DATA_LO + 32'd1, SZ_HALF, 32'd0, 1'b1));
      send_access(make_access(ACT_LOAD, DATA_LO, SZ_RESERVED, 32'd0, 1'b1));
      send_access(make_access(ACT_STORE, DATA_LO + 32'd16, SZ_RESERVED, 32'h1234_5677, 1'b0));
      send_access(make_access(ACT_LOAD, DATA_LO + 32'd16, SZ_RESERVED, 32'd0, 1'b0));
      send_access(make_access(ACT_LOAD, DATA_LO + 32'd16, SZ_BYTE, 32'd0, 1'b1));
      send_access(make_access(ACT_LOAD, 32'h2000_0001, SZ_WORD, 32'd0, 1'b1));
      send_access(make_access(ACT_LOAD, STACK_HI + 32'd2, SZ_WORD, 32'd0, 1'b1));
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering:
   // the output register fills and the request side must stall.
   task automatic test_output_hold();
      sender_idles = 1'b0;
      hold_request = 1'b1;
      repeat (30) send_access(random_access());
      wait_for_drain();
   endtask

   // Sender pauses with nothing in flight, then picks up again.
   task automatic test_drain_then_resume();
      sender_idles = 1'b1;
      repeat (10) send_access(random_access());
      wait_for_drain();
      repeat (10) send_access(random_access());
      wait_for_drain();
   endtask

   task automatic test_random_accesses();
      window_base[4] = STACK_LO + $urandom_range(1, 8190) * 64;
      window_base[5] = DATA_LO + $urandom_range(1, 4094) * 64;
      // each segment picks bursty or back-to-back sending at random, mostly bursty
      for (int seg = 0; seg < 8; seg++) begin
         sender_idles = ($urandom_range(0, 3) != 0);
         repeat (85) send_access(random_access());
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_LOAD;
      req_vaddr       = 32'd0;
      req_access_size = SZ_BYTE;
      req_write_data  = 32'd0;
      req_align_check = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_segment_edges();
      test_fault_cases();
      test_output_hold();
      test_drain_then_resume();
      test_random_accesses();

      wait_for_drain();
      // anything arriving now is a response with no request behind it
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("** segmented_load_store_unit: PASSED **");
      else
         $display("** segmented_load_store_unit: FAILED **");
      $finish;
   end

   // Receiver stall pattern: stretches of no stall, light and heavy random
   // stall and a fixed period, plus the long hold on request.
   initial begin : rsp_stall_pattern
      int unsigned mode;
      int unsigned span;
      int unsigned phase;
      int unsigned hold_left;
      rsp_stall = 1'b0;
      mode      = 0;
      span      = 0;
      phase     = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
         end
         span--;
         phase++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 0);
               2: rsp_stall <= ($urandom_range(0, 4) != 0);
               default: rsp_stall <= (phase % 3 == 0);
            endcase
         end
      end
   end

   // Response checker: every transfer against the oldest prediction.
   always @(posedge clock) begin : check_results
      mem_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected response: read_data %h, status %0d",
                   rsp_read_data, rsp_status);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: too long without a transfer on either channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** segmented_load_store_unit: FAILED **");
         $finish;
      end
   end

endmodule
